FILE: hw/rtl/fie_pkg.sv
// Package for the fuzzy inference engine: widths, function codes and shared types.
// No dependencies.
`default_nettype none
package fie_pkg;
   localparam int MAX_RULES_DEF    = 64;
   localparam int NUM_VARS_DEF     = 4;
   localparam int NUM_SETS_DEF     = 8;
   localparam int NUM_OUT_SETS_DEF = 16;
   localparam logic [6:0]  RULE_COUNT_RST = 7'd50;
   localparam logic [12:0] MIN_WSUM_RST   = 13'd1;
   localparam logic [12:0] ONE_Q12        = 13'd4096;
   localparam logic        REG_RULE_COUNT = 1'b0;
   localparam logic        REG_MIN_WSUM   = 1'b1;

   typedef enum logic [1:0] {
      FUNC_LOAD_MF  = 2'd0,
      FUNC_LOAD_OUT = 2'd1,
      FUNC_LOAD_RULE = 2'd2,
      FUNC_EVAL     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      SHAPE_TRAP  = 2'd0,
      SHAPE_LEFT  = 2'd1,
      SHAPE_RIGHT = 2'd2,
      SHAPE_NONE  = 2'd3
   } shape_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SLOPE, ST_WALK, ST_DIV, ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [15:0] pa;
      logic signed [15:0] pb;
      logic signed [15:0] pc;
      logic signed [15:0] pd;
      shape_type          shape;
      logic [24:0]        s1;
      logic [24:0]        s2;
   } trap_type;

   typedef struct packed {
      logic        start;
      logic [25:0] num;
      logic [17:0] den;
   } div_req_type;
endpackage
`default_nettype wire

FILE: hw/rtl/fie_lane.sv
// One antecedent lane: clipped trapezoid membership of a measured value.
// Depends on fie_pkg. Registered output.
`default_nettype none
module fie_lane
   import fie_pkg::*;
(
   input  wire logic               clock,
   input  wire logic signed [15:0] x,
   input  wire trap_type           trap,
   output logic [12:0]             mu
);
   logic [12:0] mu_in;
   logic [12:0] mu_ff;
   logic [16:0] span;
   logic [24:0] slope;
   logic        use_ramp;
   logic [12:0] fixed_val;
   logic [16:0] span_ff;
   logic [24:0] slope_ff;
   logic        ramp_ff;
   logic [12:0] fixed_ff;
   logic [41:0] prod;

   always_comb begin
      use_ramp  = 1'b0;
      fixed_val = 13'd0;
      span      = 17'd0;
      slope     = trap.s1;
      case (trap.shape)
         SHAPE_LEFT: begin
            if (x <= trap.pa) fixed_val = ONE_Q12;
            else if (x < trap.pb) begin
               use_ramp = 1'b1;
               span = 17'(18'(trap.pb) - 18'(x));
            end
         end
         SHAPE_RIGHT: begin
            if (x >= trap.pb && x > trap.pa) fixed_val = ONE_Q12;
            else if (x > trap.pa) begin
               use_ramp = 1'b1;
               span = 17'(18'(x) - 18'(trap.pa));
            end
         end
         SHAPE_TRAP: begin
            if (x <= trap.pa || x >= trap.pd) fixed_val = 13'd0;
            else if (x >= trap.pb && x <= trap.pc) fixed_val = ONE_Q12;
            else if (x <= trap.pb) begin
               use_ramp = 1'b1;
               span = 17'(18'(x) - 18'(trap.pa));
            end else begin
               use_ramp = 1'b1;
               span  = 17'(18'(trap.pd) - 18'(x));
               slope = trap.s2;
            end
         end
         default: fixed_val = 13'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      span_ff  <= span;
      slope_ff <= slope;
      ramp_ff  <= use_ramp;
      fixed_ff <= fixed_val;
   end

   assign prod = span_ff * slope_ff;

   always_comb begin
      if (!ramp_ff) mu_in = fixed_ff;
      else if (prod[41:12] > 30'(ONE_Q12)) mu_in = ONE_Q12;
      else mu_in = prod[24:12];
   end

   always_ff @(posedge clock) mu_ff <= mu_in;
   assign mu = mu_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/fie_div.sv
// Restoring divider, one quotient bit a cycle; unsigned numerator and divisor.
// Depends on fie_pkg.
`default_nettype none
module fie_div
   import fie_pkg::*;
#(
   parameter int NW = 40,
   parameter int DW = 19
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               busy,
   output logic [NW-1:0]      quot
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] d_ff, d_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; d_in = d_ff;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; cnt_in = CW'(NW);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign busy = (cnt_ff != '0);
   assign quot = q_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/fuzzy_inference_engine.sv
// Fuzzy inference engine top level: tables, rule walk, merge and division.
// Depends on fie_pkg, fie_lane, fie_div.
//
// Usage: words enter on req_ (tvalid/tready/tdata, tuser = func). Loads of
// memberships, singletons and rules produce no word; an evaluate word
// produces one rsp_ word with the drive and the no-rule flag.
// A membership load works through two serial slope divisions of 40 quotient
// bits each and a table write before the next word is taken; other loads are
// written on acceptance. An evaluate walks rule_count rules, capped at
// MAX_RULES, one after another, each through rule read, table read, two lane
// stages, product and accumulate, with two lanes working on the antecedents
// side by side, and then does a serial division.
// One word is worked on at a time; req_tready is low while busy.
// If the receiver stalls, the result holds in rsp_tdata and the block
// takes no new word until it is taken.
// Reset returns control to idle and the registers to 50 and 1; the
// tables are undefined until written.
// csr_: write enable, index and 13-bit data, taken at once.
`default_nettype none
module fuzzy_inference_engine
   import fie_pkg::*;
#(
   parameter int MAX_RULES    = MAX_RULES_DEF,
   parameter int NUM_VARS     = NUM_VARS_DEF,
   parameter int NUM_SETS     = NUM_SETS_DEF,
   parameter int NUM_OUT_SETS = NUM_OUT_SETS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // slot, var_a, set_a, var_b, set_b, out_set, word0..word3, shape, pad
   input  wire logic [87:0] req_tdata,
   // func
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // drive, no_rule_fired, pad
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [12:0] csr_wdata
);
   localparam int NTRAP = NUM_VARS * NUM_SETS;
   localparam int TW    = $clog2(NTRAP);
   localparam int RW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int OW    = $clog2(NUM_OUT_SETS);

   logic [5:0]  f_slot;
   logic [1:0]  f_va, f_vb;
   logic [2:0]  f_sa, f_sb;
   logic [3:0]  f_os;
   logic signed [15:0] f_w [4];
   shape_type   f_shape;
   func_type    f_func;

   assign f_slot = req_tdata[5:0];
   assign f_va   = req_tdata[7:6];
   assign f_sa   = req_tdata[10:8];
   assign f_vb   = req_tdata[12:11];
   assign f_sb   = req_tdata[15:13];
   assign f_os   = req_tdata[19:16];
   assign f_w[0] = req_tdata[35:20];
   assign f_w[1] = req_tdata[51:36];
   assign f_w[2] = req_tdata[67:52];
   assign f_w[3] = req_tdata[83:68];
   assign f_shape = shape_type'(req_tdata[85:84]);
   assign f_func  = func_type'(req_tuser);

   logic [6:0]  rule_count_ff;
   logic [12:0] min_wsum_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= RULE_COUNT_RST;
         min_wsum_ff   <= MIN_WSUM_RST;
      end else if (csr_we) begin
         if (csr_index == REG_RULE_COUNT) rule_count_ff <= csr_wdata[6:0];
         else min_wsum_ff <= csr_wdata;
      end
   end

   trap_type    trap_mem [NTRAP];
   logic [15:0] out_mem  [NUM_OUT_SETS];
   logic [13:0] rule_mem [MAX_RULES];

   state_type state_ff, state_in;
   logic [8:0]  n_ff, n_in;
   logic [8:0]  k_ff, k_in;
   logic [2:0]  ph_ff, ph_in;
   logic        sl_ff, sl_in;
   logic signed [15:0] x_ff [4];
   trap_type    ld_ff;
   logic [TW-1:0] ld_idx_ff;
   logic [13:0] rule_ff;
   logic        rule_ok_ff;
   trap_type    ta_ff, tb_ff;
   logic signed [15:0] xa_ff, xb_ff, sing_ff;
   logic [12:0] mu_a, mu_b;
   logic signed [47:0] sum1_ff, sum1_in;
   logic [18:0] sum2_ff, sum2_in;
   logic        flag_ff, flag_in, neg_ff, neg_in;
   logic signed [15:0] drive_ff, drive_in;
   logic        wr_rule, wr_out, wr_trap;
   logic        div_start;
   logic [39:0] div_num;
   logic [18:0] div_den;
   logic        div_busy;
   logic [39:0] div_q;
   logic [12:0] wt;
   logic signed [29:0] prod_ff;
   logic [12:0] wt_ff;
   logic signed [16:0] diff;
   logic [24:0] slope_q;
   logic [47:0] abs_sum1;

   fie_lane u_lane_a (.clock(clock), .x(xa_ff), .trap(ta_ff), .mu(mu_a));
   fie_lane u_lane_b (.clock(clock), .x(xb_ff), .trap(tb_ff), .mu(mu_b));

   fie_div #(.NW(40), .DW(19)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .busy(div_busy), .quot(div_q)
   );

   assign wr_rule = req_tvalid && req_tready && f_func == FUNC_LOAD_RULE
                    && 9'(f_slot) < 9'(MAX_RULES);
   assign wr_out  = req_tvalid && req_tready && f_func == FUNC_LOAD_OUT
                    && 7'(f_slot) < 7'(NUM_OUT_SETS);

   always_ff @(posedge clock) begin
      if (wr_rule) rule_mem[RW'(f_slot)] <= {f_os, f_sb, f_vb, f_sa, f_va};
      if (wr_out) out_mem[OW'(f_slot)] <= f_w[0];
      if (wr_trap) trap_mem[ld_idx_ff] <= ld_ff;
      rule_ff <= rule_mem[k_ff[RW-1:0]];
   end

   // per-rule reads: the rule word first, then both membership entries and the singleton together
   always_ff @(posedge clock) begin
      if (state_ff == ST_WALK) begin
         case (ph_ff)
            3'd1: begin
               rule_ok_ff <= 5'(rule_ff[1:0]) < 5'(NUM_VARS) && 5'(rule_ff[6:5]) < 5'(NUM_VARS)
                  && 5'(rule_ff[4:2]) < 5'(NUM_SETS) && 5'(rule_ff[9:7]) < 5'(NUM_SETS)
                  && 6'(rule_ff[13:10]) < 6'(NUM_OUT_SETS);
               ta_ff <= trap_mem[TW'(32'(rule_ff[1:0]) * NUM_SETS + 32'(rule_ff[4:2]))];
               tb_ff <= trap_mem[TW'(32'(rule_ff[6:5]) * NUM_SETS + 32'(rule_ff[9:7]))];
               xa_ff <= x_ff[rule_ff[1:0]];
               xb_ff <= x_ff[rule_ff[6:5]];
               sing_ff <= out_mem[OW'(rule_ff[13:10])];
            end
            default: ;
         endcase
      end
   end

   assign wt = (mu_b < mu_a) ? mu_b : mu_a;
   always_ff @(posedge clock) begin
      prod_ff <= $signed({17'd0, wt}) * sing_ff;
      wt_ff   <= wt;
   end

   assign diff = sl_ff ? 17'(ld_ff.pd) - 17'(ld_ff.pc) : 17'(ld_ff.pb) - 17'(ld_ff.pa);
   assign slope_q = div_q[24:0];
   assign abs_sum1 = sum1_ff[47] ? 48'(-sum1_ff) : 48'(sum1_ff);

   always_comb begin
      state_in = state_ff; n_in = n_ff; k_in = k_ff; ph_in = ph_ff; sl_in = sl_ff;
      sum1_in = sum1_ff; sum2_in = sum2_ff; flag_in = flag_ff; neg_in = neg_ff;
      drive_in = drive_ff;
      req_tready = 1'b0; rsp_tvalid = 1'b0; wr_trap = 1'b0;
      div_start = 1'b0; div_num = '0; div_den = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (f_func == FUNC_LOAD_MF && 3'(f_va) < 3'(NUM_VARS)
                   && 5'(f_sa) < 5'(NUM_SETS)) begin
                  state_in = ST_SLOPE; sl_in = 1'b0; ph_in = 3'd0;
               end else if (f_func == FUNC_EVAL) begin
                  n_in = (9'(rule_count_ff) > 9'(MAX_RULES)) ? 9'(MAX_RULES)
                                                             : 9'(rule_count_ff);
                  k_in = '0; ph_in = 3'd0; sum1_in = '0; sum2_in = '0;
                  state_in = (n_in == '0) ? ST_DIV : ST_WALK;
               end
            end
         end
         ST_SLOPE: begin
            if (ph_ff == 3'd0) begin
               div_start = 1'b1;
               div_num = 40'd16777216;
               div_den = 19'(diff);
               ph_in = 3'd1;
            end else if (ph_ff == 3'd2) begin
               wr_trap = 1'b1;
               state_in = ST_IDLE;
            end else if (!div_busy) begin
               ph_in = sl_ff ? 3'd2 : 3'd0;
               sl_in = 1'b1;
            end
         end
         ST_WALK: begin
            // read rule, read tables, lane stage, lane stage, product, accumulate
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd5) begin
               if (rule_ok_ff) begin
                  sum1_in = sum1_ff + 48'(prod_ff);
                  sum2_in = sum2_ff + 19'(wt_ff);
               end
               ph_in = 3'd0;
               k_in = k_ff + 9'd1;
               if (k_in == n_ff) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (ph_ff == 3'd0) begin
               flag_in = (sum2_ff == '0) || (sum2_ff < 19'(min_wsum_ff));
               neg_in = sum1_ff[47];
               div_start = 1'b1;
               div_num = abs_sum1[39:0];
               div_den = sum2_ff;
               ph_in = 3'd1;
            end else if (!div_busy) begin
               if (flag_ff) drive_in = '0;
               else if (neg_ff) drive_in = (div_q > 40'd32768) ? 16'sh8000 : 16'(-div_q);
               else drive_in = (div_q > 40'd32767) ? 16'sh7FFF : 16'(div_q);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
      end
      n_ff <= n_in; k_ff <= k_in; sl_ff <= sl_in;
      sum1_ff <= sum1_in; sum2_ff <= sum2_in;
      flag_ff <= flag_in; neg_ff <= neg_in; drive_ff <= drive_in;
      if (state_ff == ST_SLOPE && ph_ff == 3'd1 && !div_busy) begin
         if (sl_ff) ld_ff.s2 <= (diff[16] || diff == '0) ? '0 : slope_q;
         else ld_ff.s1 <= (diff[16] || diff == '0) ? '0 : slope_q;
      end
      if (state_ff == ST_IDLE && req_tvalid) begin
         ld_ff.pa <= f_w[0]; ld_ff.pb <= f_w[1];
         ld_ff.pc <= f_w[2]; ld_ff.pd <= f_w[3];
         ld_ff.shape <= f_shape;
         ld_idx_ff <= TW'(32'(f_va) * NUM_SETS + 32'(f_sa));
         for (int i = 0; i < 4; i++) x_ff[i] <= f_w[i];
      end
   end

   assign rsp_tdata = {7'd0, flag_ff, drive_ff};

`ifndef SYNTHESIS
   a_out_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == ST_OUT) else $error("rsp without result");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("req taken while holding rsp");
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && flag_ff) |-> drive_ff == '0) else $error("flag with drive");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> k_ff < n_ff) else $error("rule index overrun");
`endif
endmodule
`default_nettype wire

FILE: sim/fuzzy_inference_engine_tb.sv
// Testbench for fuzzy_inference_engine: table loads, rule walks and checked evaluations
// under random idling and back-pressure, against a predictor of its own.
// Depends on fie_pkg and the fuzzy_inference_engine RTL.
`default_nettype none
module fuzzy_inference_engine_tb;
   import fie_pkg::*;

   localparam int   SETTLE_CYCLES  = 400;

   typedef struct {
      func_type           fn;
      logic [5:0]         slot;
      logic [1:0]         va;
      logic [2:0]         sa;
      logic [1:0]         vb;
      logic [2:0]         sb;
      logic [3:0]         os;
      logic signed [15:0] w [4];
      shape_type          shp;
   } req_word_type;

   typedef struct {
      int        pa, pb, pc, pd;
      shape_type shp;
      longint    s1, s2;
   } trap_entry_type;

   typedef struct {
      logic [1:0] va, vb;
      logic [2:0] sa, sb;
      logic [3:0] os;
   } rule_entry_type;

   typedef struct {
      logic signed [15:0] drive;
      logic               flag;
   } drive_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [12:0] csr_wdata = '0;

   trap_entry_type   trap_tbl [32];
   logic signed [15:0] sing_tbl [16];
   rule_entry_type   rule_tbl [64];
   int unsigned   walk_count = 50;
   int unsigned   weight_floor = 1;

   drive_result_type drive_queue [$];
   int errors = 0;
   int n_loads = 0, n_evals = 0, n_checked = 0, n_flagged = 0;
   int tx_idle_pct = 0, rx_idle_pct = 0;
   int rx_hold = 0;

   fuzzy_inference_engine dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #30000000;
      $display("timeout at %0t", $time);
      $display("** fuzzy_inference_engine: FAILED **");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic longint slope_q24(int lo, int hi);
      int diff;
      diff = hi - lo;
      if (diff <= 0) return 0;
      return 64'd16777216 / diff;
   endfunction

   function automatic int ramp_q12(int span, longint s);
      longint m;
      m = (longint'(span) * s) >>> 12;
      if (m > 4096) m = 4096;
      return int'(m);
   endfunction

   function automatic int grade_of(int x, trap_entry_type t);
      case (t.shp)
         SHAPE_LEFT: begin
            if (x <= t.pa) return 4096;
            if (x >= t.pb) return 0;
            return ramp_q12(t.pb - x, t.s1);
         end
         SHAPE_RIGHT: begin
            if (x <= t.pa) return 0;
            if (x >= t.pb) return 4096;
            return ramp_q12(x - t.pa, t.s1);
         end
         SHAPE_TRAP: begin
            if (x <= t.pa || x >= t.pd) return 0;
            if (x >= t.pb && x <= t.pc) return 4096;
            if (x <= t.pb) return ramp_q12(x - t.pa, t.s1);
            return ramp_q12(t.pd - x, t.s2);
         end
         default: return 0;
      endcase
   endfunction

   task automatic predict_word(req_word_type r);
      trap_entry_type   e;
      rule_entry_type   ru;
      drive_result_type res;
      longint        acc_num, acc_den, q;
      int            n, m0, m1, wt;
      case (r.fn)
         FUNC_LOAD_MF: begin
            e.pa = r.w[0]; e.pb = r.w[1]; e.pc = r.w[2]; e.pd = r.w[3];
            e.shp = r.shp;
            e.s1 = slope_q24(e.pa, e.pb);
            e.s2 = slope_q24(e.pc, e.pd);
            trap_tbl[{r.va, r.sa}] = e;
            n_loads++;
         end
         FUNC_LOAD_OUT: begin
            if (r.slot < 16) sing_tbl[r.slot] = r.w[0];
            n_loads++;
         end
         FUNC_LOAD_RULE: begin
            ru.va = r.va; ru.sa = r.sa; ru.vb = r.vb; ru.sb = r.sb; ru.os = r.os;
            rule_tbl[r.slot] = ru;
            n_loads++;
         end
         default: begin
            acc_num = 0;
            acc_den = 0;
            n = (walk_count > 64) ? 64 : walk_count;
            for (int k = 0; k < n; k++) begin
               m0 = grade_of(r.w[rule_tbl[k].va], trap_tbl[{rule_tbl[k].va, rule_tbl[k].sa}]);
               m1 = grade_of(r.w[rule_tbl[k].vb], trap_tbl[{rule_tbl[k].vb, rule_tbl[k].sb}]);
               wt = (m1 < m0) ? m1 : m0;
               acc_num += longint'(wt) * longint'(sing_tbl[rule_tbl[k].os]);
               acc_den += wt;
            end
            if (acc_den == 0 || acc_den < weight_floor) begin
               res.drive = '0;
               res.flag = 1'b1;
            end else begin
               q = acc_num / acc_den;
               if (q > 32767) q = 32767;
               if (q < -32768) q = -32768;
               res.drive = q[15:0];
               res.flag = 1'b0;
            end
            drive_queue.push_back(res);
            n_evals++;
         end
      endcase
   endtask

   // ---------------- result side ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold = rx_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      drive_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_queue.size() == 0) begin
            $display("%0t: unexpected word drive=%0d flag=%0b", $time,
                     $signed(rsp_tdata[15:0]), rsp_tdata[16]);
            errors++;
         end else begin
            exp_r = drive_queue.pop_front();
            n_checked++;
            if (exp_r.flag) n_flagged++;
            if (rsp_tdata[15:0] !== exp_r.drive) begin
               $display("%0t: drive expected %0d actual %0d", $time, exp_r.drive,
                        $signed(rsp_tdata[15:0]));
               errors++;
            end
            if (rsp_tdata[16] !== exp_r.flag) begin
               $display("%0t: no_rule_fired expected %0b actual %0b", $time, exp_r.flag,
                        rsp_tdata[16]);
               errors++;
            end
         end
      end
   end

   // ---------------- request side ----------------
   task automatic send_word(req_word_type r);
      req_tvalid <= 1'b1;
      req_tuser  <= r.fn;
      req_tdata  <= {2'b00, r.shp, r.w[3], r.w[2], r.w[1], r.w[0],
                     r.os, r.sb, r.vb, r.sa, r.va, r.slot};
      do @(posedge clock); while (!req_tready);
      predict_word(r);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic go_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (drive_queue.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [12:0] val);
      go_quiet();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_RULE_COUNT) walk_count = val[6:0];
      else weight_floor = val;
   endtask

   function automatic req_word_type blank_word(func_type fn);
      req_word_type r;
      r.fn = fn; r.slot = '0; r.va = '0; r.sa = '0; r.vb = '0; r.sb = '0; r.os = '0;
      for (int i = 0; i < 4; i++) r.w[i] = '0;
      r.shp = SHAPE_TRAP;
      return r;
   endfunction

   function automatic logic signed [15:0] clip16(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic req_word_type rand_mf(logic [1:0] va, logic [2:0] sa);
      req_word_type r;
      int p;
      r = blank_word(FUNC_LOAD_MF);
      r.va = va; r.sa = sa;
      r.shp = shape_type'($urandom_range(9) == 0 ? 3 : $urandom_range(2));
      if ($urandom_range(99) < 15) begin
         for (int i = 0; i < 4; i++) r.w[i] = 16'($urandom);
      end else begin
         p = $urandom_range(36000) - 20000;
         for (int i = 0; i < 4; i++) begin
            r.w[i] = clip16(p);
            p += $urandom_range(4000);
         end
      end
      return r;
   endfunction

   function automatic req_word_type rand_rule(logic [5:0] slot);
      req_word_type r;
      r = blank_word(FUNC_LOAD_RULE);
      r.slot = slot;
      r.va = 2'($urandom); r.sa = 3'($urandom); r.vb = 2'($urandom);
      r.sb = 3'($urandom); r.os = 4'($urandom);
      return r;
   endfunction

   function automatic req_word_type rand_eval();
      req_word_type r;
      r = blank_word(FUNC_EVAL);
      for (int i = 0; i < 4; i++)
         r.w[i] = ($urandom_range(4) == 0) ? 16'($urandom) :
                  clip16($urandom_range(40000) - 20000);
      r.slot = 6'($urandom); r.shp = shape_type'($urandom_range(3));
      return r;
   endfunction

   function automatic req_word_type rand_any();
      req_word_type r;
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         r = rand_mf(2'($urandom), 3'($urandom));
      end else if (pick < 25) begin
         r = blank_word(FUNC_LOAD_OUT);
         r.slot = 6'($urandom_range(19));
         r.w[0] = 16'($urandom);
      end else if (pick < 45) begin
         r = rand_rule(6'($urandom));
      end else begin
         r = rand_eval();
      end
      return r;
   endfunction

   // ---------------- tests ----------------
   task automatic test_table_fill();
      req_word_type r;
      for (int i = 0; i < 32; i++) send_word(rand_mf(i[4:3], i[2:0]));
      for (int i = 0; i < 16; i++) begin
         r = blank_word(FUNC_LOAD_OUT);
         r.slot = 6'(i);
         r.w[0] = 16'($urandom);
         send_word(r);
      end
      for (int i = 0; i < 64; i++) send_word(rand_rule(6'(i)));
   endtask

   task automatic test_directed();
      req_word_type r;
      send_word(rand_eval());
      r = blank_word(FUNC_LOAD_MF);
      r.w[0] = -16'sd32768; r.w[1] = 16'sd32767; r.w[2] = -16'sd32768; r.w[3] = 16'sd32767;
      send_word(r);
      r.shp = SHAPE_LEFT; r.va = 2'd1; send_word(r);
      r.shp = SHAPE_RIGHT; r.va = 2'd2; send_word(r);
      r.shp = SHAPE_NONE; r.va = 2'd3; r.sa = 3'd7; send_word(r);
      r = blank_word(FUNC_LOAD_MF);
      r.sa = 3'd1; r.w[0] = 16'sd100; r.w[1] = 16'sd100; r.w[2] = 16'sd50; r.w[3] = 16'sd10;
      send_word(r);
      r = blank_word(FUNC_LOAD_MF);
      r.sa = 3'd2; r.w[0] = 16'sd0; r.w[1] = 16'sd1; r.w[2] = 16'sd2; r.w[3] = 16'sd3;
      send_word(r);
      r = blank_word(FUNC_LOAD_OUT);
      r.slot = 6'd15; r.w[0] = 16'sd32767; send_word(r);
      r.slot = 6'd0; r.w[0] = -16'sd32768; send_word(r);
      r.slot = 6'd63; r.w[0] = 16'sd1234; send_word(r);
      r = blank_word(FUNC_LOAD_RULE);
      r.slot = 6'd63; r.va = 2'd3; r.sa = 3'd7; r.vb = 2'd3; r.sb = 3'd7; r.os = 4'd15;
      send_word(r);
      r.slot = 6'd0; r.va = 2'd0; r.sa = 3'd0; r.vb = 2'd1; r.sb = 3'd0; r.os = 4'd0;
      send_word(r);
      r = blank_word(FUNC_EVAL);
      for (int i = 0; i < 4; i++) r.w[i] = -16'sd32768;
      send_word(r);
      for (int i = 0; i < 4; i++) r.w[i] = 16'sd32767;
      send_word(r);
      for (int i = 0; i < 4; i++) r.w[i] = 16'sd1;
      send_word(r);
      for (int i = 0; i < 4; i++) r.w[i] = 16'sd0;
      send_word(r);
   endtask

   task automatic test_reg_extremes();
      write_reg(REG_RULE_COUNT, 13'd0);
      write_reg(REG_MIN_WSUM, 13'd0);
      repeat (3) send_word(rand_eval());
      write_reg(REG_RULE_COUNT, 13'd127);
      repeat (3) send_word(rand_eval());
      write_reg(REG_RULE_COUNT, 13'd64);
      write_reg(REG_MIN_WSUM, 13'd4096);
      repeat (3) send_word(rand_eval());
      write_reg(REG_MIN_WSUM, 13'd8191);
      repeat (2) send_word(rand_eval());
      write_reg(REG_RULE_COUNT, 13'd1);
      write_reg(REG_MIN_WSUM, 13'd1);
      repeat (3) send_word(rand_eval());
   endtask

   task automatic test_random_phase(int tx_pct, int rx_pct, int count);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      write_reg(REG_RULE_COUNT, 13'($urandom_range(64, 8)));
      write_reg(REG_MIN_WSUM, 13'($urandom_range(200)));
      for (int i = 0; i < count; i++) begin
         send_word(rand_any());
         if (i % 150 == 149) write_reg(REG_RULE_COUNT, 13'($urandom_range(127)));
      end
   endtask

   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold = 3000;
      repeat (20) send_word(rand_eval());
   endtask

   task automatic finish_run();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (drive_queue.size() > 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (drive_queue.size() > 0) begin
         $display("%0t: %0d expected words never arrived", $time, drive_queue.size());
         errors++;
      end
      $display("covered %0d loads and %0d evaluations, %0d results checked (%0d flagged)",
               n_loads, n_evals, n_checked, n_flagged);
      $display("register extremes, idle sender and receiver phases and a long receiver stall");
      if (errors == 0) begin
         $display("** fuzzy_inference_engine: PASSED **");
      end else begin
         $display("** fuzzy_inference_engine: FAILED **");
      end
      $finish;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_fill();
      test_directed();
      test_reg_extremes();
      test_random_phase(37, 73, 400);
      test_random_phase(73, 37, 400);
      test_random_phase(0, 0, 400);
      test_backpressure();
      finish_run();
   end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/fie_pkg.sv
hw/rtl/fie_lane.sv
hw/rtl/fie_div.sv
hw/rtl/fuzzy_inference_engine.sv
sim/fuzzy_inference_engine_tb.sv
